>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the alpha unit, used by the output stage
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> hw/rtl/apu_pkg.sv
// Shared types and codes for the alpha premultiply/unpremultiply unit
package apu_pkg;

  // Operation select
  typedef enum logic {
    OP_PREMUL   = 1'b0,
    OP_UNPREMUL = 1'b1
  } op_t;

  // Per-item control that travels down the cell chain
  typedef struct packed {
    logic valid;
    op_t  op;
    logic neg;   // sample was negative
    logic zero;  // clamped alpha is zero
  } apu_ctl_t;

endpackage

>>> hw/rtl/apu_front.sv
// Input stage: alpha clamp, premultiply product, sample magnitude
module apu_front import apu_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          func,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] alpha,
  output apu_ctl_t                      ctl,
  output logic [SAMPLE_BITS-1:0]        pre,
  output logic [SAMPLE_BITS-1:0]        mag,
  output logic [FRAC_BITS:0]            div
);

  localparam logic [SAMPLE_BITS-2:0] ONE_W = (SAMPLE_BITS-1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0]     ONE   = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [FRAC_BITS:0]                    a_clamp;
  logic signed [SAMPLE_BITS+FRAC_BITS+1:0] prod;
  logic [SAMPLE_BITS-1:0]                sample_u;
  logic [SAMPLE_BITS-1:0]                mag_c;

  // Clamp alpha to [0, 1.0]
  always_comb begin
    if (alpha[SAMPLE_BITS-1]) begin
      a_clamp = '0;
    end else if (alpha[SAMPLE_BITS-2:0] > ONE_W) begin
      a_clamp = ONE;
    end else begin
      a_clamp = alpha[FRAC_BITS:0];
    end
  end

  // Premultiply: arithmetic shift of the product keeps floor rounding
  assign prod = sample * $signed({1'b0, a_clamp});

  // Magnitude of the sample for the divider
  assign sample_u = $unsigned(sample);
  assign mag_c    = sample_u[SAMPLE_BITS-1] ? (~sample_u + 1'b1) : sample_u;

  // Control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= start;
      ctl.op    <= op_t'(func);
      ctl.neg   <= sample_u[SAMPLE_BITS-1];
      ctl.zero  <= (a_clamp == '0);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pre <= prod[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS];
    mag <= mag_c;
    div <= a_clamp;
  end

endmodule

>>> hw/rtl/apu_cell.sv
// One restoring-division cell: develops one quotient bit per item
module apu_cell import apu_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  apu_ctl_t               ctl_in,
  input  logic [SAMPLE_BITS-1:0] pre_in,
  input  logic [SAMPLE_BITS-1:0] mag_in,
  input  logic [FRAC_BITS:0]     div_in,
  input  logic [FRAC_BITS:0]     rem_in,
  input  logic [SAMPLE_BITS:0]   q_in,
  input  logic                   big_in,
  output apu_ctl_t               ctl_out,
  output logic [SAMPLE_BITS-1:0] pre_out,
  output logic [SAMPLE_BITS-1:0] mag_out,
  output logic [FRAC_BITS:0]     div_out,
  output logic [FRAC_BITS:0]     rem_out,
  output logic [SAMPLE_BITS:0]   q_out,
  output logic                   big_out
);

  logic [FRAC_BITS+1:0] trial;
  logic [FRAC_BITS+1:0] diff;
  logic                 ge;
  logic [FRAC_BITS:0]   rem_next;

  // Bring down the next numerator bit and try the subtract
  assign trial    = {rem_in, mag_in[SAMPLE_BITS-1]};
  assign diff     = trial - {1'b0, div_in};
  assign ge       = (trial >= {1'b0, div_in});
  assign rem_next = ge ? diff[FRAC_BITS:0] : trial[FRAC_BITS:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  // Quotient keeps its low bits; anything shifted out is sticky overflow
  always_ff @(posedge clk) begin
    pre_out <= pre_in;
    mag_out <= {mag_in[SAMPLE_BITS-2:0], 1'b0};
    div_out <= div_in;
    rem_out <= rem_next;
    q_out   <= {q_in[SAMPLE_BITS-1:0], ge};
    big_out <= big_in | q_in[SAMPLE_BITS];
  end

endmodule

>>> hw/rtl/apu_back.sv
// Output stage: sign, zero-alpha case, saturation and result register
`include "assert_macros.svh"
module apu_back import apu_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  apu_ctl_t                      ctl_in,
  input  logic [SAMPLE_BITS-1:0]        pre_in,
  input  logic [SAMPLE_BITS:0]          q_in,
  input  logic                          big_in,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] result,
  output logic                          saturated
);

  localparam logic [SAMPLE_BITS-1:0] MAX_V = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] MIN_V = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                   over;
  logic [SAMPLE_BITS-1:0] q_low;
  logic [SAMPLE_BITS-1:0] result_next;
  logic                   saturated_next;

  assign q_low = q_in[SAMPLE_BITS-1:0];

  // Magnitude beyond the bound of the result's sign
  always_comb begin
    if (ctl_in.neg) begin
      over = big_in | q_in[SAMPLE_BITS] |
             (q_in[SAMPLE_BITS-1] & (|q_in[SAMPLE_BITS-2:0]));
    end else begin
      over = big_in | q_in[SAMPLE_BITS] | q_in[SAMPLE_BITS-1];
    end
  end

  // Result select
  always_comb begin
    result_next    = pre_in;
    saturated_next = 1'b0;
    case (ctl_in.op)
      OP_PREMUL: begin
        result_next = pre_in;
      end
      OP_UNPREMUL: begin
        if (ctl_in.zero) begin
          result_next = '0;
        end else if (over) begin
          result_next    = ctl_in.neg ? MIN_V : MAX_V;
          saturated_next = 1'b1;
        end else begin
          result_next = ctl_in.neg ? (~q_low + 1'b1) : q_low;
        end
      end
      default: begin
        result_next = pre_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    result    <= $signed(result_next);
    saturated <= saturated_next;
  end

  // Premultiply never clips
  `ASSERT_PROP(a_premul_nosat, clk, rst, (ctl_in.valid && ctl_in.op == OP_PREMUL) |=> !saturated)
  // Zero alpha on unpremultiply gives zero
  `ASSERT_PROP(a_zero_alpha, clk, rst, (ctl_in.valid && ctl_in.op == OP_UNPREMUL && ctl_in.zero) |=> (result == '0 && !saturated))
  // A clipped result sits on one of the bounds
  `ASSERT_PROP(a_sat_bound, clk, rst, (done && saturated) |-> ($unsigned(result) == MAX_V || $unsigned(result) == MIN_V))

endmodule

>>> hw/rtl/alpha_premultiply_unpremultiply_unit.sv
// Alpha premultiply / unpremultiply unit, top level.
// Takes one item per clock: busy is held low, so start is always taken.
// Each item runs through an input stage, a chain of SAMPLE_BITS+FRAC_BITS
// division cells (one quotient bit per cell) and an output stage, 42 registers
// at the default sizes. done and the result come from the output stage registers
// together; items leave in order, and done is one cycle long per item.
// The receiver cannot stall; results must be taken when done is high.
// Premultiply items ride the same chain, so both operations pass the same registers.
module alpha_premultiply_unpremultiply_unit import apu_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] alpha,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] result,
  output logic                          saturated
);

  localparam int NCELL = SAMPLE_BITS + FRAC_BITS;

  apu_ctl_t               ctl_c [0:NCELL];
  logic [SAMPLE_BITS-1:0] pre_c [0:NCELL];
  logic [SAMPLE_BITS-1:0] mag_c [0:NCELL];
  logic [FRAC_BITS:0]     div_c [0:NCELL];
  logic [FRAC_BITS:0]     rem_c [0:NCELL];
  logic [SAMPLE_BITS:0]   q_c   [0:NCELL];
  logic                   big_c [0:NCELL];

  // Fully pipelined: never refuses an item
  assign busy = 1'b0;

  apu_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .sample(sample),
    .alpha (alpha),
    .ctl   (ctl_c[0]),
    .pre   (pre_c[0]),
    .mag   (mag_c[0]),
    .div   (div_c[0])
  );

  // Divider starts from an empty remainder and quotient
  assign rem_c[0] = '0;
  assign q_c[0]   = '0;
  assign big_c[0] = 1'b0;

  // Chain of division cells
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    apu_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl_c[i]),
      .pre_in (pre_c[i]),
      .mag_in (mag_c[i]),
      .div_in (div_c[i]),
      .rem_in (rem_c[i]),
      .q_in   (q_c[i]),
      .big_in (big_c[i]),
      .ctl_out(ctl_c[i+1]),
      .pre_out(pre_c[i+1]),
      .mag_out(mag_c[i+1]),
      .div_out(div_c[i+1]),
      .rem_out(rem_c[i+1]),
      .q_out  (q_c[i+1]),
      .big_out(big_c[i+1])
    );
  end

  apu_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (ctl_c[NCELL]),
    .pre_in   (pre_c[NCELL]),
    .q_in     (q_c[NCELL]),
    .big_in   (big_c[NCELL]),
    .done     (done),
    .result   (result),
    .saturated(saturated)
  );

endmodule
